// File: hw/rtl/dnsc_pkg.sv
// Shared types and constants for the DNS name syntax checker.
// Holds the per-name state record and its start-of-name value.
// No dependencies.
`timescale 1ns / 1ps

package dnsc_pkg;

	// Character codes that the checker recognises.
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Limits on a label, the wire form, the name length and an escape value.
	localparam logic [5:0] LABEL_MAX      = 6'd63;
	localparam logic [8:0] WIRE_MAX       = 9'd255;
	localparam logic [8:0] NAME_CHARS_MAX = 9'd255;
	localparam logic [9:0] ESC_VALUE_MAX  = 10'd255;

	// Escape phase: none, after a backslash, one digit pending, two digits pending.
	typedef enum logic [3:0] {
		ESC_NONE  = 4'b0001,
		ESC_SLASH = 4'b0010,
		ESC_DIG1  = 4'b0100,
		ESC_DIG2  = 4'b1000
	} dnsc_esc_t;

	// Everything the checker remembers between characters of one name.
	typedef struct packed {
		logic [5:0] label_count;
		logic [8:0] wire_count;
		logic [8:0] char_count;
		dnsc_esc_t  escape_phase;
		logic [6:0] digit_value;
		logic       failed;
		logic       root_candidate;
	} dnsc_state_t;

	// State at the start of every name; the wire count already holds the root byte.
	localparam dnsc_state_t STATE_RESET = '{
		label_count:    6'd0,
		wire_count:     9'd1,
		char_count:     9'd0,
		escape_phase:   ESC_NONE,
		digit_value:    7'd0,
		failed:         1'b0,
		root_candidate: 1'b0
	};

endpackage

// File: hw/rtl/dnsc_step.sv
// Combinational update of the name state for one character, with the verdict
// for a final character. Depends on dnsc_pkg.
`timescale 1ns / 1ps

module dnsc_step
	import dnsc_pkg::*;
(
	input  dnsc_state_t cur_state,
	input  logic [7:0]  name_char,
	input  logic        last_char,
	output dnsc_state_t next_state,
	output logic        name_ok
);

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Adds one character to the current label, failing on the label or wire limit.
	function automatic dnsc_state_t add_label(dnsc_state_t s);
		dnsc_state_t r;
		r = s;
		if (!s.failed) begin
			if ((s.label_count >= LABEL_MAX) ||
			    (({3'b000, s.label_count} + s.wire_count + 9'd2) > WIRE_MAX)) begin
				r.failed = 1'b1;
			end else begin
				r.label_count = s.label_count + 6'd1;
			end
		end
		return r;
	endfunction

	// An unescaped character: a dot closes a label, a backslash opens an escape.
	function automatic dnsc_state_t plain_char(dnsc_state_t s, logic [7:0] c);
		dnsc_state_t r;
		r = s;
		if (c == CH_DOT) begin
			if (s.label_count == 6'd0) begin
				r.failed = 1'b1;
			end else begin
				r.wire_count  = s.wire_count + {3'b000, s.label_count} + 9'd1;
				r.label_count = 6'd0;
			end
		end else if (c == CH_BSLASH) begin
			r.escape_phase = ESC_SLASH;
		end else begin
			r = add_label(s);
		end
		return r;
	endfunction

	// One character through the escape phases.
	function automatic dnsc_state_t take_char(dnsc_state_t s, logic [7:0] c);
		dnsc_state_t r;
		logic [9:0]  dec;
		r   = s;
		dec = ({3'b000, s.digit_value} << 3) + ({3'b000, s.digit_value} << 1)
		      + {6'd0, c[3:0]};
		case (s.escape_phase)
			ESC_NONE: begin
				r = plain_char(s, c);
			end
			ESC_SLASH: begin
				if (is_digit(c)) begin
					r.digit_value  = {3'b000, c[3:0]};
					r.escape_phase = ESC_DIG1;
				end else begin
					r              = add_label(s);
					r.escape_phase = ESC_NONE;
				end
			end
			ESC_DIG1: begin
				if (is_digit(c)) begin
					r.digit_value  = dec[6:0];
					r.escape_phase = ESC_DIG2;
				end else begin
					// Broken escape: the digit stands as a label character.
					r.escape_phase = ESC_NONE;
					r = add_label(r);
					if (!r.failed) r = plain_char(r, c);
				end
			end
			ESC_DIG2: begin
				r.escape_phase = ESC_NONE;
				if (is_digit(c)) begin
					if (dec > ESC_VALUE_MAX) r.failed = 1'b1;
					else r = add_label(r);
				end else begin
					// Broken escape: both digits stand as label characters.
					r = add_label(r);
					r = add_label(r);
					if (!r.failed) r = plain_char(r, c);
				end
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	dnsc_state_t upd;
	dnsc_state_t fin;
	logic [9:0]  wire_end;

	// Character count, root detection and the character itself.
	always_comb begin
		upd = cur_state;
		if ((cur_state.char_count == 9'd0) && (name_char == CH_DOT)) begin
			upd.root_candidate = 1'b1;
		end
		if (cur_state.char_count >= NAME_CHARS_MAX) begin
			upd.failed = 1'b1;
		end else begin
			upd.char_count = cur_state.char_count + 9'd1;
		end
		if (!upd.failed) upd = take_char(upd, name_char);
	end

	// End of name: settle a pending escape and close the last label.
	always_comb begin
		fin = upd;
		if (!upd.failed) begin
			case (upd.escape_phase)
				ESC_SLASH: fin.failed = 1'b1;
				ESC_DIG1:  fin = add_label(upd);
				ESC_DIG2:  fin = add_label(add_label(upd));
				default:   fin = upd;
			endcase
		end
		wire_end = {1'b0, fin.wire_count};
		if (!fin.failed && (fin.label_count != 6'd0)) begin
			wire_end = {1'b0, fin.wire_count} + {4'd0, fin.label_count} + 10'd1;
		end
		name_ok = (!fin.failed && (wire_end <= {1'b0, WIRE_MAX})) ||
		          (fin.root_candidate && (fin.char_count == 9'd1));
	end

	assign next_state = last_char ? STATE_RESET : upd;

endmodule

// File: hw/rtl/dns_name_syntax_checker.sv
// The verdict is registered: the final character passes the input register and then
// the result register; it waits in the input register while a verdict is pending.
// Throughput: one character per cycle, but for that wait, held by the single state
// update per cycle through the character step logic between input and state registers.
// Reset: arst_n (asynchronous, active low) empties the input and result registers
// and returns the name state to the start of a name.
// Top level of the DNS name syntax checker; depends on dnsc_pkg and dnsc_step.
`timescale 1ns / 1ps

module dns_name_syntax_checker
	import dnsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] name_char,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       name_ok
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	dnsc_state_t state_q;
	dnsc_state_t state_next;
	logic        ok_next;
	logic        out_valid_q;
	logic        name_ok_q;
	logic        out_free;
	logic        advance;

	// A request leaves the input register when its verdict, if any, has a free slot.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= name_char;
			last_s1 <= last_char;
		end
	end

	dnsc_step u_step (
		.cur_state  (state_q),
		.name_char  (char_s1),
		.last_char  (last_s1),
		.next_state (state_next),
		.name_ok    (ok_next)
	);

	// Name state, updated once per character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			name_ok_q <= ok_next;
		end
	end

	assign out_valid = out_valid_q;
	assign name_ok   = name_ok_q;

	// A final character always leaves the state ready for a fresh name.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (state_q == STATE_RESET))
		else $error("name state not restarted after final character");

	// A new verdict never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> out_free)
		else $error("verdict written over a pending result");

	// The wire count stays within the wire limit and never drops below the root byte.
	a_wire_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.wire_count <= WIRE_MAX) && (state_q.wire_count != 9'd0))
		else $error("wire count out of range");

	// The character count saturates at the name limit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.char_count <= NAME_CHARS_MAX)
		else $error("character count beyond name limit");

	// A stalled final character keeps its place in the input register.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && !advance) |=> (valid_s1 && last_s1 && $stable(char_s1)))
		else $error("stalled final character lost");

endmodule
